// ----- design/dwra_pkg.sv -----
// ----------------------------------------------------------------------------
// dwra_pkg: shared types, constants and date helpers
// Day numbering, window lengths, register indexes and channel payloads.
// ----------------------------------------------------------------------------
package dwra_pkg;

  localparam int DAYS_PER_YEAR = 365;
  localparam int COUNT_MAX     = 65535;
  localparam int MEAN_W        = 12;
  localparam int COUNT_W       = 16;
  localparam int SUM_W         = 32;
  localparam int DAY_W         = 16;
  localparam int LEN_W         = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 7;

  // restoring divide: one quotient bit per step, mean always fits MEAN_W bits
  localparam int DIV_STEPS     = MEAN_W;
  localparam int ITER_W        = $clog2(DIV_STEPS);

  // x / 18 as (x * RECIP_18) >> RECIP_SHIFT, exact for x < 74898
  localparam int RECIP_SHIFT   = 20;
  localparam int RECIP_18      = 58255;
  localparam int PROD_W        = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAL_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MG_DL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TODAY_YEAR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TODAY_MONTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TODAY_DAY     = 3'd5;

  localparam logic [1:0] MEAL_ALL    = 2'd0;
  localparam logic [1:0] MEAL_BEFORE = 2'd1;
  localparam logic [1:0] MEAL_AFTER  = 2'd2;

  localparam logic [2:0] WIN_SEL_MAX = 3'd4;

  localparam logic [LEN_W-1:0] WIN_LEN [5] = '{7'd7, 7'd14, 7'd30, 7'd60, 7'd90};

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [6:0] record_year;
    logic [3:0] record_month;
    logic [4:0] record_day;
    logic [11:0] reading_value;
    logic       control_test;
    logic       before_meal;
    logic       after_meal;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [11:0] mean_value;
    logic [15:0] reading_count;
    logic        has_readings;
    logic [6:0]  window_days;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic load;
    logic step;
    logic conv;
    logic put;
  } dp_cmd_t;

  typedef struct packed {
    logic last_pend;
  } dp_status_t;

  // days since the first of January 2000, modulo 2^16
  function automatic logic [DAY_W-1:0] day_num(input logic [6:0] y, input logic [3:0] m,
                                               input logic [4:0] d);
    logic [3:0]       mc;
    logic [DAY_W-1:0] n;
    mc = (m > 4'd12) ? 4'd12 : m;
    n = DAY_W'(y) * DAY_W'(DAYS_PER_YEAR);
    if (mc != 4'd0) n = n + DAY_W'(DAYS_BEFORE[mc - 4'd1]);
    n = n + DAY_W'(d) - DAY_W'(1);
    n = n + DAY_W'((8'(y) + 8'd3) >> 2);
    if (mc > 4'd2 && y[1:0] == 2'd0) n = n + DAY_W'(1);
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] win_len(input logic [2:0] sel);
    logic [2:0] s;
    s = (sel > WIN_SEL_MAX) ? WIN_SEL_MAX : sel;
    return WIN_LEN[s];
  endfunction

endpackage

// ----- design/dated_window_reading_average_top.sv -----
// ----------------------------------------------------------------------------
// dated_window_reading_average_top: windowed glucose reading average
// Filters dated records by window, meal tag and test flag; emits count and mean per set.
//
//   channel | dir | handshake             | payload
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in  | in_valid / in_ready   | in_data (in_item_t)
//   out     | out | out_valid / out_ready | out_data (out_item_t)
//
// Records are taken one per cycle when in_ready is high, filtered on entry and
// added in the next cycle; after a last record come the accumulator drain, the
// divider load, 12 steps of the bit-serial divider, the unit multiply and the
// result load. The result sits in an output register; the next set may stream
// in meanwhile, but its own result holds off requests until that register frees.
// Reset is synchronous; config writes are always taken (cfg_ready is high).
// ----------------------------------------------------------------------------
module dated_window_reading_average_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dwra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dwra_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dwra_pkg::out_item_t              out_data
);

  dwra_pkg::dp_cmd_t    cmd;
  dwra_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  dwra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dwra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ----- design/dwra_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwra_ctrl: sequencing controller
// Runs accumulate, divider load, divide steps, unit conversion and result put.
// ----------------------------------------------------------------------------
module dwra_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dwra_pkg::dp_status_t  status,
  output dwra_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIV,
    ST_CONV,
    ST_PUT
  } state_t;

  state_t                        state;
  logic [dwra_pkg::ITER_W-1:0]   iter;
  logic                          out_free;

  // the last record of a set must reach the accumulators before anything else
  assign in_ready = (state == ST_ACCUM) && !status.last_pend;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.take = in_valid && in_ready;
    cmd.load = (state == ST_LOAD);
    cmd.step = (state == ST_DIV);
    cmd.conv = (state == ST_CONV);
    cmd.put  = (state == ST_PUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_ACCUM: begin
          if (status.last_pend) state <= ST_LOAD;
        end
        ST_LOAD: begin
          iter  <= dwra_pkg::ITER_W'(dwra_pkg::DIV_STEPS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (iter == '0) state <= ST_CONV;
          else iter <= iter - dwra_pkg::ITER_W'(1);
        end
        ST_CONV: begin
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_blocks_input: assert property (@(posedge clk) disable iff (rst)
    status.last_pend |-> !in_ready)
    else $error("input taken while last record pending");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ##(dwra_pkg::DIV_STEPS + 1) (state == ST_CONV))
    else $error("divide did not run its full step count");

  a_result_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_PUT))
    else $error("result raised outside put state");
`endif

endmodule

// ----- design/dwra_dp.sv -----
// ----------------------------------------------------------------------------
// dwra_dp: datapath
// Registers, record filter, accumulators, serial divider and unit converter.
// ----------------------------------------------------------------------------
module dwra_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dwra_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dwra_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  dwra_pkg::in_item_t                    in_data,
  input  dwra_pkg::dp_cmd_t                     cmd,
  output dwra_pkg::dp_status_t                  status,
  output dwra_pkg::out_item_t                   out_data
);

  // configuration
  logic [2:0] window_select;
  logic [1:0] meal_mode;
  logic       unit_mg_dl;
  logic [6:0] today_year;
  logic [3:0] today_month;
  logic [4:0] today_day;

  // filter stage
  logic                              stg_valid;
  logic                              stg_keep;
  logic                              stg_last;
  logic [11:0]                       stg_value;
  logic [dwra_pkg::LEN_W-1:0]        stg_len;

  logic [dwra_pkg::SUM_W-1:0]        value_sum;
  logic [dwra_pkg::COUNT_W-1:0]      kept_count;

  // divider and converter
  logic [dwra_pkg::COUNT_W-1:0]      div_rem;
  logic [dwra_pkg::COUNT_W-1:0]      div_den;
  logic [dwra_pkg::MEAN_W-1:0]       div_quo;
  logic [dwra_pkg::LEN_W-1:0]        res_len;
  logic [dwra_pkg::PROD_W-1:0]       prod;

  logic [dwra_pkg::LEN_W-1:0]        len;
  logic [dwra_pkg::DAY_W:0]          end_day;
  logic [dwra_pkg::DAY_W:0]          rec_day;
  logic [dwra_pkg::DAY_W:0]          len_ext;
  logic                              in_win;
  logic                              meal_ok;
  logic                              keep;
  logic [dwra_pkg::COUNT_W:0]        shifted;
  logic [dwra_pkg::COUNT_W+1:0]      diff;
  logic                              ge;
  logic [15:0]                       conv_x;
  logic [dwra_pkg::MEAN_W-1:0]       mean_sel;

  assign len     = dwra_pkg::win_len(window_select);
  assign end_day = {1'b0, dwra_pkg::day_num(today_year, today_month, today_day)};
  assign rec_day = {1'b0, dwra_pkg::day_num(in_data.record_year, in_data.record_month,
                                            in_data.record_day)};
  assign len_ext = (dwra_pkg::DAY_W + 1)'(len);

  assign in_win = (end_day + 17'd1 >= len_ext) && (rec_day + len_ext >= end_day + 17'd1) &&
                  (rec_day <= end_day);

  always_comb begin
    case (meal_mode)
      dwra_pkg::MEAL_BEFORE: meal_ok = in_data.before_meal;
      dwra_pkg::MEAL_AFTER:  meal_ok = in_data.after_meal;
      default:               meal_ok = 1'b1;
    endcase
  end

  assign keep = !in_data.control_test && in_win && meal_ok;

  assign status.last_pend = stg_valid && stg_last;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {div_rem, div_quo[dwra_pkg::MEAN_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_den};
  assign ge      = !diff[dwra_pkg::COUNT_W+1];

  assign conv_x  = 16'(div_quo) * 16'd10 + 16'd9;

  always_comb begin
    if (div_den == '0)   mean_sel = '0;
    else if (unit_mg_dl) mean_sel = div_quo;
    else                 mean_sel = prod[dwra_pkg::RECIP_SHIFT +: dwra_pkg::MEAN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_select <= 3'd0;
      meal_mode     <= 2'd0;
      unit_mg_dl    <= 1'b0;
      today_year    <= 7'd0;
      today_month   <= 4'd1;
      today_day     <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        dwra_pkg::CFG_WINDOW_SELECT: window_select <= cfg_data[2:0];
        dwra_pkg::CFG_MEAL_MODE:     meal_mode     <= cfg_data[1:0];
        dwra_pkg::CFG_UNIT_MG_DL:    unit_mg_dl    <= cfg_data[0];
        dwra_pkg::CFG_TODAY_YEAR:    today_year    <= cfg_data[6:0];
        dwra_pkg::CFG_TODAY_MONTH:   today_month   <= cfg_data[3:0];
        dwra_pkg::CFG_TODAY_DAY:     today_day     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= cmd.take;
    end
    if (cmd.take) begin
      stg_keep  <= keep;
      stg_last  <= in_data.is_last;
      stg_value <= in_data.reading_value;
      stg_len   <= len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      value_sum  <= '0;
      kept_count <= '0;
    end else if (stg_valid && stg_keep &&
                 kept_count != dwra_pkg::COUNT_W'(dwra_pkg::COUNT_MAX)) begin
      value_sum  <= value_sum + dwra_pkg::SUM_W'(stg_value);
      kept_count <= kept_count + dwra_pkg::COUNT_W'(1);
    end
  end

  // the sum never reaches count * 2^12, so its top bits start below the divisor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_rem <= value_sum[dwra_pkg::MEAN_W +: dwra_pkg::COUNT_W];
      div_quo <= value_sum[dwra_pkg::MEAN_W-1:0];
      div_den <= kept_count;
      res_len <= stg_len;
    end else if (cmd.step) begin
      div_rem <= ge ? diff[dwra_pkg::COUNT_W-1:0] : shifted[dwra_pkg::COUNT_W-1:0];
      div_quo <= {div_quo[dwra_pkg::MEAN_W-2:0], ge};
    end
    if (cmd.conv) begin
      prod <= dwra_pkg::PROD_W'(conv_x) * dwra_pkg::PROD_W'(dwra_pkg::RECIP_18);
    end
    if (cmd.put) begin
      out_data.mean_value    <= mean_sel;
      out_data.reading_count <= div_den;
      out_data.has_readings  <= (div_den != '0);
      out_data.window_days   <= res_len;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && div_den != '0) |-> (div_rem < div_den))
    else $error("divider remainder out of range");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (value_sum == '0 && kept_count == '0))
    else $error("accumulators not cleared after divider load");
`endif

endmodule
